// ===== rtl/core/quoted_string_unescape_utf8_core_defines.svh =====
// Assertion macros shared by the checker of the string unescape core.
`ifndef QUOTED_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define QUOTED_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define QSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define QSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qsu_pkg.sv =====
// Types and constants of the quoted string unescape core.
`timescale 1ns / 1ps
`default_nettype none

package qsu_pkg;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_BARE       = 4'd1,
        PH_BODY       = 4'd2,
        PH_ESC        = 4'd3,
        PH_HEX        = 4'd4,
        PH_WANT_BSL   = 4'd5,
        PH_WANT_U     = 4'd6,
        PH_SPACE      = 4'd7,
        PH_MARK       = 4'd8,
        PH_LINE       = 4'd9,
        PH_BLOCK      = 4'd10,
        PH_BLOCK_STAR = 4'd11
    } phase_t;

    localparam logic [1:0] QK_NONE   = 2'd0;
    localparam logic [1:0] QK_DOUBLE = 2'd1;
    localparam logic [1:0] QK_SINGLE = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_BAD_START     = 4'd1;
    localparam logic [3:0] ERR_QUOTE_ESCAPE  = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX       = 4'd3;
    localparam logic [3:0] ERR_LOW_RANGE     = 4'd4;
    localparam logic [3:0] ERR_LOW_MISSING   = 4'd5;
    localparam logic [3:0] ERR_LONE_LOW      = 4'd6;
    localparam logic [3:0] ERR_ILLEGAL_ESC   = 4'd7;
    localparam logic [3:0] ERR_UNTERMINATED  = 4'd8;
    localparam logic [3:0] ERR_NUL_IN_BLOCK  = 4'd9;
    localparam logic [3:0] ERR_OPEN_COMMENT  = 4'd10;

    // Parse state carried from one item to the next.
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  quote_kind;
        logic [1:0]  hex_digits_seen;
        logic [15:0] code_accum;
        logic [15:0] high_surrogate;
        logic        in_second_escape;
    } state_t;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] error_code;
        logic       not_consumed;
    } res_t;

    // All results of one input item, entry 0 first.
    typedef struct packed {
        logic [2:0]     count;
        res_t [3:0]     res;
    } group_t;

endpackage

`default_nettype wire

// ===== rtl/core/qsu_decode.sv =====
// Combinational decode of one token byte: next parse state and its results.
`timescale 1ns / 1ps
`default_nettype none

module qsu_decode (
    input  qsu_pkg::state_t st,
    input  logic [7:0]      in_byte,
    input  logic            token_start,
    input  logic            end_of_text,
    output qsu_pkg::state_t st_next,
    output qsu_pkg::group_t grp
);
    import qsu_pkg::*;

    function automatic res_t mk(input logic [1:0] kind, input logic [7:0] b,
                                input logic [3:0] err, input logic nc);
        res_t r;
        r.kind         = kind;
        r.out_byte     = b;
        r.error_code   = err;
        r.not_consumed = nc;
        return r;
    endfunction

    function automatic logic is_bare(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z") || b == "-" || b == "+" || b == "_" || b == ".";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= "0" && b <= "9") begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end else if (b >= "A" && b <= "F") begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end else if (b >= "a" && b <= "f") begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    logic        do_body;
    logic        do_emit;
    logic [20:0] cp;
    logic [4:0]  hv;
    logic [15:0] accum_new;
    logic [26:0] sur_sum;

    always_comb begin
        st_next   = st;
        grp       = '0;
        do_body   = 1'b0;
        do_emit   = 1'b0;
        cp        = '0;
        hv        = hex_value(in_byte);
        accum_new = {st.code_accum[11:0], hv[3:0]};
        sur_sum   = {1'b0, st.high_surrogate, 10'b0} + {11'b0, accum_new} - 27'h35FDC00;

        if (token_start) begin
            st_next = '0;
            if (end_of_text) begin
                grp.res[0] = mk(KIND_ERR, 8'h00, ERR_BAD_START, 1'b0);
                grp.count  = 3'd1;
            end else if (in_byte == "\"") begin
                st_next.quote_kind = QK_DOUBLE;
                st_next.phase      = PH_BODY;
            end else if (in_byte == "'") begin
                st_next.quote_kind = QK_SINGLE;
                st_next.phase      = PH_BODY;
            end else if (is_bare(in_byte)) begin
                st_next.phase = PH_BARE;
                grp.res[0]    = mk(KIND_DATA, in_byte, ERR_NONE, 1'b0);
                grp.count     = 3'd1;
            end else begin
                grp.res[0] = mk(KIND_ERR, 8'h00, ERR_BAD_START, 1'b0);
                grp.count  = 3'd1;
            end
        end else if (end_of_text) begin
            st_next.phase = PH_IDLE;
            grp.count     = 3'd1;
            case (st.phase)
                PH_BARE: begin
                    grp.res[0] = mk(KIND_DONE, 8'h00, ERR_NONE, 1'b0);
                end
                PH_BODY, PH_SPACE: begin
                    grp.res[0] = mk(KIND_ERR, 8'h00, ERR_UNTERMINATED, 1'b0);
                end
                PH_ESC: begin
                    grp.res[0] = mk(KIND_ERR, 8'h00, ERR_ILLEGAL_ESC, 1'b0);
                end
                PH_HEX: begin
                    grp.res[0] = mk(KIND_ERR, 8'h00, ERR_BAD_HEX, 1'b0);
                end
                PH_WANT_BSL, PH_WANT_U: begin
                    grp.res[0] = mk(KIND_ERR, 8'h00, ERR_LOW_MISSING, 1'b0);
                end
                PH_MARK, PH_LINE, PH_BLOCK, PH_BLOCK_STAR: begin
                    grp.res[0] = mk(KIND_ERR, 8'h00, ERR_OPEN_COMMENT, 1'b0);
                end
                default: begin
                    st_next.phase = st.phase;
                    grp.count     = 3'd0;
                end
            endcase
        end else begin
            case (st.phase)
                PH_BARE: begin
                    grp.count = 3'd1;
                    if (is_bare(in_byte)) begin
                        grp.res[0] = mk(KIND_DATA, in_byte, ERR_NONE, 1'b0);
                    end else begin
                        st_next.phase = PH_IDLE;
                        grp.res[0]    = mk(KIND_DONE, 8'h00, ERR_NONE, 1'b1);
                    end
                end
                PH_BODY: begin
                    do_body = 1'b1;
                end
                PH_ESC: begin
                    st_next.phase = PH_BODY;
                    grp.count     = 3'd1;
                    grp.res[0]    = mk(KIND_DATA, in_byte, ERR_NONE, 1'b0);
                    case (in_byte)
                        8'h0A, 8'h0D: begin
                            st_next.phase = PH_SPACE;
                            grp.count     = 3'd0;
                        end
                        "\"": begin
                            if (st.quote_kind != QK_DOUBLE) begin
                                st_next.phase = PH_IDLE;
                                grp.res[0] = mk(KIND_ERR, 8'h00, ERR_QUOTE_ESCAPE, 1'b0);
                            end
                        end
                        "'": begin
                            if (st.quote_kind != QK_SINGLE) begin
                                st_next.phase = PH_IDLE;
                                grp.res[0] = mk(KIND_ERR, 8'h00, ERR_QUOTE_ESCAPE, 1'b0);
                            end
                        end
                        "\\", "/": begin
                            grp.res[0] = mk(KIND_DATA, in_byte, ERR_NONE, 1'b0);
                        end
                        "b": grp.res[0] = mk(KIND_DATA, 8'h08, ERR_NONE, 1'b0);
                        "f": grp.res[0] = mk(KIND_DATA, 8'h0C, ERR_NONE, 1'b0);
                        "n": grp.res[0] = mk(KIND_DATA, 8'h0A, ERR_NONE, 1'b0);
                        "r": grp.res[0] = mk(KIND_DATA, 8'h0D, ERR_NONE, 1'b0);
                        "t": grp.res[0] = mk(KIND_DATA, 8'h09, ERR_NONE, 1'b0);
                        "v": grp.res[0] = mk(KIND_DATA, 8'h0B, ERR_NONE, 1'b0);
                        "u": begin
                            st_next.phase            = PH_HEX;
                            st_next.hex_digits_seen  = 2'd0;
                            st_next.code_accum       = 16'h0000;
                            st_next.in_second_escape = 1'b0;
                            grp.count                = 3'd0;
                        end
                        default: begin
                            st_next.phase = PH_IDLE;
                            grp.res[0] = mk(KIND_ERR, 8'h00, ERR_ILLEGAL_ESC, 1'b0);
                        end
                    endcase
                end
                PH_HEX: begin
                    if (!hv[4]) begin
                        st_next.phase = PH_IDLE;
                        grp.res[0]    = mk(KIND_ERR, 8'h00, ERR_BAD_HEX, 1'b0);
                        grp.count     = 3'd1;
                    end else begin
                        st_next.code_accum = accum_new;
                        if (st.hex_digits_seen != 2'd3) begin
                            st_next.hex_digits_seen = st.hex_digits_seen + 2'd1;
                        end else begin
                            st_next.hex_digits_seen = 2'd0;
                            if (st.in_second_escape) begin
                                st_next.in_second_escape = 1'b0;
                                if (accum_new < 16'hDC00 || accum_new > 16'hDFFF) begin
                                    st_next.phase = PH_IDLE;
                                    grp.res[0] = mk(KIND_ERR, 8'h00, ERR_LOW_RANGE, 1'b0);
                                    grp.count  = 3'd1;
                                end else begin
                                    st_next.phase = PH_BODY;
                                    cp            = sur_sum[20:0];
                                    do_emit       = 1'b1;
                                end
                            end else if (accum_new >= 16'hD800 && accum_new <= 16'hDBFF) begin
                                st_next.high_surrogate = accum_new;
                                st_next.phase          = PH_WANT_BSL;
                            end else if (accum_new >= 16'hDC00 && accum_new <= 16'hDFFF) begin
                                st_next.phase = PH_IDLE;
                                grp.res[0]    = mk(KIND_ERR, 8'h00, ERR_LONE_LOW, 1'b0);
                                grp.count     = 3'd1;
                            end else begin
                                st_next.phase = PH_BODY;
                                cp            = {5'b0, accum_new};
                                do_emit       = 1'b1;
                            end
                        end
                    end
                end
                PH_WANT_BSL: begin
                    if (in_byte == "\\") begin
                        st_next.phase = PH_WANT_U;
                    end else begin
                        st_next.phase = PH_IDLE;
                        grp.res[0]    = mk(KIND_ERR, 8'h00, ERR_LOW_MISSING, 1'b0);
                        grp.count     = 3'd1;
                    end
                end
                PH_WANT_U: begin
                    if (in_byte == "u") begin
                        st_next.phase            = PH_HEX;
                        st_next.hex_digits_seen  = 2'd0;
                        st_next.code_accum       = 16'h0000;
                        st_next.in_second_escape = 1'b1;
                    end else begin
                        st_next.phase = PH_IDLE;
                        grp.res[0]    = mk(KIND_ERR, 8'h00, ERR_LOW_MISSING, 1'b0);
                        grp.count     = 3'd1;
                    end
                end
                PH_SPACE: begin
                    if (is_space(in_byte)) begin
                        st_next.phase = PH_SPACE;
                    end else if (in_byte == "/" || in_byte == "#" || in_byte == ";") begin
                        st_next.phase = PH_MARK;
                    end else begin
                        do_body = 1'b1;
                    end
                end
                PH_MARK: begin
                    st_next.phase = (in_byte == "*") ? PH_BLOCK : PH_LINE;
                end
                PH_LINE: begin
                    if (in_byte == 8'h0A || in_byte == 8'h0D || in_byte == 8'h00) begin
                        st_next.phase = PH_SPACE;
                    end
                end
                PH_BLOCK: begin
                    if (in_byte == 8'h00) begin
                        st_next.phase = PH_IDLE;
                        grp.res[0]    = mk(KIND_ERR, 8'h00, ERR_NUL_IN_BLOCK, 1'b0);
                        grp.count     = 3'd1;
                    end else if (in_byte == "*") begin
                        st_next.phase = PH_BLOCK_STAR;
                    end
                end
                PH_BLOCK_STAR: begin
                    if (in_byte == 8'h00) begin
                        st_next.phase = PH_IDLE;
                        grp.res[0]    = mk(KIND_ERR, 8'h00, ERR_NUL_IN_BLOCK, 1'b0);
                        grp.count     = 3'd1;
                    end else if (in_byte == "/") begin
                        st_next.phase = PH_SPACE;
                    end else if (in_byte != "*") begin
                        st_next.phase = PH_BLOCK;
                    end
                end
                default: begin
                    st_next.phase = PH_IDLE;
                end
            endcase
        end

        // An ordinary string byte: closing quote, start of an escape, or copied.
        if (do_body) begin
            st_next.phase = PH_BODY;
            if ((in_byte == "\"" && st.quote_kind == QK_DOUBLE) ||
                (in_byte == "'" && st.quote_kind == QK_SINGLE)) begin
                st_next.phase = PH_IDLE;
                grp.res[0]    = mk(KIND_DONE, 8'h00, ERR_NONE, 1'b0);
                grp.count     = 3'd1;
            end else if (in_byte == "\\") begin
                st_next.phase = PH_ESC;
            end else begin
                grp.res[0] = mk(KIND_DATA, in_byte, ERR_NONE, 1'b0);
                grp.count  = 3'd1;
            end
        end

        // UTF-8 encoding of a finished code point.
        if (do_emit) begin
            if (cp < 21'h80) begin
                grp.res[0] = mk(KIND_DATA, cp[7:0], ERR_NONE, 1'b0);
                grp.count  = 3'd1;
            end else if (cp <= 21'h7FF) begin
                grp.res[0] = mk(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE, 1'b0);
                grp.res[1] = mk(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b0);
                grp.count  = 3'd2;
            end else if (cp <= 21'hFFFF) begin
                grp.res[0] = mk(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE, 1'b0);
                grp.res[1] = mk(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
                grp.res[2] = mk(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b0);
                grp.count  = 3'd3;
            end else begin
                grp.res[0] = mk(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE, 1'b0);
                grp.res[1] = mk(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE, 1'b0);
                grp.res[2] = mk(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
                grp.res[3] = mk(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b0);
                grp.count  = 3'd4;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/quoted_string_unescape_utf8_core.sv =====
// Top level of the quoted string unescape core with UTF-8 output.
//
//  channel | direction | tdata                               | tuser               | tlast
//  --------+-----------+-------------------------------------+---------------------+---------
//  s_      | in        | in_byte[7:0]                        | token_start[0],     | -
//          |           |                                     | end_of_text[1]      |
//  m_      | out       | out_byte[7:0], error_code[11:8],    | out_kind[1:0]       | last
//          |           | byte_not_consumed[12], zero [15:13] |                     |
//
// Items that yield at most one result flow at one a cycle while m_tready is high; an item
// that yields k results keeps the next item waiting in the input register until its group
// has drained, since a group drains through the m_ port one item per cycle while m_tready
// is high. An accepted item passes the input register and then the group register.
// Reset (aresetn low at a clock edge) empties both registers and returns the parser to idle.
// A stall on m_tready backs up into s_tready once the input register holds an item.
`timescale 1ns / 1ps
`default_nettype none

module quoted_string_unescape_utf8_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic [1:0]  s_tuser,   // token_start[0], end_of_text[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], error_code[11:8], byte_not_consumed[12]
    output logic [1:0]  m_tuser,   // out_kind[1:0]
    output logic        m_tlast
);
    import qsu_pkg::*;

    // Input register: one accepted item waiting for decode.
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_start_reg;
    logic            in_eot_reg;

    // Parse state and the result group of the last decoded item.
    state_t          state_reg;
    state_t          state_next;
    group_t          grp_reg;
    group_t          grp_next;
    logic            grp_valid_reg;
    logic [1:0]      rd_idx_reg;

    logic            take;
    logic            last_out;
    logic            grp_free;
    logic            move;
    res_t            cur;

    qsu_decode u_decode (
        .st          (state_reg),
        .in_byte     (in_byte_reg),
        .token_start (in_start_reg),
        .end_of_text (in_eot_reg),
        .st_next     (state_next),
        .grp         (grp_next)
    );

    // The entry on show is the last of its group once the read index plus one reaches the count.
    assign last_out = ({1'b0, rd_idx_reg} + 3'd1) == grp_reg.count;
    assign take     = grp_valid_reg && m_tready;
    // The group register takes a new decode when it is empty or its last entry leaves now.
    assign grp_free = !grp_valid_reg || (take && last_out);
    assign move     = in_valid_reg && grp_free;
    assign s_tready = !in_valid_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (move) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_eot_reg   <= s_tuser[1];
        end
    end

    // The parse state advances exactly when an item is decoded into the group register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            grp_valid_reg <= 1'b0;
            rd_idx_reg    <= 2'd0;
        end else if (move) begin
            state_reg     <= state_next;
            grp_valid_reg <= grp_next.count != 3'd0;
            rd_idx_reg    <= 2'd0;
        end else if (take) begin
            if (last_out) begin
                grp_valid_reg <= 1'b0;
            end else begin
                rd_idx_reg <= rd_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            grp_reg <= grp_next;
        end
    end

    assign cur      = grp_reg.res[rd_idx_reg];
    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = {3'b000, cur.not_consumed, cur.error_code, cur.out_byte};
    assign m_tuser  = cur.kind;
    assign m_tlast  = last_out;

endmodule

`default_nettype wire

// ===== rtl/core/qsu_checker.sv =====
// Port-level checks of the quoted string unescape core, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_string_unescape_utf8_core_defines.svh"

module qsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import qsu_pkg::*;

    // A stalled result holds its contents.
    `QSU_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // A finish or an error always closes the results of its input item.
    `QSU_ASSERT_NOW(a_end_is_last, m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERR), m_tlast, "finish or error not marked last")

    // Data items carry no error code and no unconsumed flag.
    `QSU_ASSERT_NOW(a_data_clean, m_tvalid && m_tuser == KIND_DATA, m_tdata[15:8] == 8'h00, "data item with error bits")

    // Only a finish can leave its byte unconsumed, and then it carries no byte.
    `QSU_ASSERT_NOW(a_nc_on_done, m_tvalid && m_tdata[12], m_tuser == KIND_DONE && m_tdata[7:0] == 8'h00, "unconsumed flag outside a finish")

    // s_tready is low only while a result waits whose group does not close at this edge.
    `QSU_ASSERT_NOW(a_ready_stall, s_tvalid && !s_tready, m_tvalid && !(m_tready && m_tlast), "input stalled without output stall")

endmodule

bind quoted_string_unescape_utf8_core qsu_checker u_qsu_checker (.*);

`default_nettype wire

// ===== tb/quoted_string_unescape_utf8_core_test.sv =====
// Self-checking testbench of the quoted string unescape core, with a built-in decoder model.
`timescale 1ns / 1ps

module quoted_string_unescape_utf8_core_test;
    import qsu_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 300;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 10;

    // One decoded output item as the core should present it.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       nc;
        logic       last;
    } decoded_t;

    // One input item; a typed row carries its single expected result (or none) by hand.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start;
        logic       eot;
        logic       typed;
        logic       has_res;
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       nc;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = 2'b00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    stim_row_t   cur_row  = '0;
    decoded_t    decoded_q [$];
    decoded_t    step_res [$];
    stim_row_t   tok_q [$];
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent  = 0;
    bit          hold_req    = 1'b0;
    bit          rx_calm     = 1'b0;
    bit          tx_burst    = 1'b0;

    // Decoder model state.
    phase_t      parse_phase;
    logic [1:0]  open_quote;
    logic [1:0]  digit_count;
    logic [15:0] hex_word;
    logic [15:0] pending_high;
    logic        want_low;

    always #1 aclk = ~aclk;

    quoted_string_unescape_utf8_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Directed items: extremes, each special case and the simple error codes.
    stim_row_t directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, KIND_ERR,  8'h00, ERR_BAD_START,    1'b0},
        '{"\"",  1'b1, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'hFF, ERR_NONE,         1'b0},
        '{"\\",  1'b0, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"'",   1'b0, 1'b0, 1'b1, 1'b1, KIND_ERR,  8'h00, ERR_QUOTE_ESCAPE, 1'b0},
        '{"'",   1'b1, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"\\",  1'b0, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"u",   1'b0, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"F",   1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"f",   1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"F",   1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"f",   1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, KIND_ERR,  8'h00, ERR_UNTERMINATED, 1'b0},
        '{"Z",   1'b1, 1'b0, 1'b1, 1'b1, KIND_DATA, "Z",   ERR_NONE,         1'b0},
        '{"~",   1'b0, 1'b0, 1'b1, 1'b1, KIND_DONE, 8'h00, ERR_NONE,         1'b1},
        '{"A",   1'b0, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"9",   1'b1, 1'b0, 1'b1, 1'b1, KIND_DATA, "9",   ERR_NONE,         1'b0},
        '{8'hA5, 1'b0, 1'b1, 1'b1, 1'b1, KIND_DONE, 8'h00, ERR_NONE,         1'b0},
        '{8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, KIND_ERR,  8'h00, ERR_BAD_START,    1'b0},
        '{"\"",  1'b1, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{"\\",  1'b0, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00, ERR_NONE,         1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, KIND_ERR,  8'h00, ERR_ILLEGAL_ESC,  1'b0},
        '{"\\",  1'b1, 1'b0, 1'b1, 1'b1, KIND_ERR,  8'h00, ERR_BAD_START,    1'b0}
    };

    // ---------------------------------------------------------------- decoder model

    function automatic void clear_parse_state();
        parse_phase  = PH_IDLE;
        open_quote   = QK_NONE;
        digit_count  = 2'd0;
        hex_word     = 16'h0000;
        pending_high = 16'h0000;
        want_low     = 1'b0;
    endfunction

    function automatic void push_res(logic [1:0] kind, logic [7:0] data, logic [3:0] err,
                                     logic nc);
        decoded_t d;
        d.kind = kind;
        d.data = data;
        d.err  = err;
        d.nc   = nc;
        d.last = 1'b0;
        step_res = {step_res, d};
    endfunction

    function automatic void push_data(logic [7:0] data);
        push_res(KIND_DATA, data, ERR_NONE, 1'b0);
    endfunction

    // Every error drops the parser back to idle.
    function automatic void push_err(logic [3:0] err);
        parse_phase = PH_IDLE;
        push_res(KIND_ERR, 8'h00, err, 1'b0);
    endfunction

    function automatic bit is_bare(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               b == "-" || b == "+" || b == "_" || b == ".";
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "A" && b <= "F") return b - "A" + 10;
        if (b >= "a" && b <= "f") return b - "a" + 10;
        return -1;
    endfunction

    function automatic void push_utf8(logic [20:0] cp);
        if (cp < 21'h80) begin
            push_data(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            push_data({3'b110, cp[10:6]});
            push_data({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            push_data({4'b1110, cp[15:12]});
            push_data({2'b10, cp[11:6]});
            push_data({2'b10, cp[5:0]});
        end else begin
            push_data({5'b11110, cp[20:18]});
            push_data({2'b10, cp[17:12]});
            push_data({2'b10, cp[11:6]});
            push_data({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void body_char(logic [7:0] b);
        parse_phase = PH_BODY;
        if ((b == "\"" && open_quote == QK_DOUBLE) || (b == "'" && open_quote == QK_SINGLE)) begin
            parse_phase = PH_IDLE;
            push_res(KIND_DONE, 8'h00, ERR_NONE, 1'b0);
        end else if (b == "\\") begin
            parse_phase = PH_ESC;
        end else begin
            push_data(b);
        end
    endfunction

    function automatic void escape_char(logic [7:0] b);
        parse_phase = PH_BODY;
        case (b)
            8'h0A, 8'h0D: parse_phase = PH_SPACE;
            "\"": begin
                if (open_quote == QK_DOUBLE) push_data(b);
                else push_err(ERR_QUOTE_ESCAPE);
            end
            "'": begin
                if (open_quote == QK_SINGLE) push_data(b);
                else push_err(ERR_QUOTE_ESCAPE);
            end
            "\\", "/": push_data(b);
            "b": push_data(8'h08);
            "f": push_data(8'h0C);
            "n": push_data(8'h0A);
            "r": push_data(8'h0D);
            "t": push_data(8'h09);
            "v": push_data(8'h0B);
            "u": begin
                parse_phase = PH_HEX;
                digit_count = 2'd0;
                hex_word    = 16'h0000;
                want_low    = 1'b0;
            end
            default: push_err(ERR_ILLEGAL_ESC);
        endcase
    endfunction

    function automatic void hex_char(logic [7:0] b);
        int          v;
        logic [31:0] joined;
        v = hex_val(b);
        if (v < 0) begin
            push_err(ERR_BAD_HEX);
            return;
        end
        hex_word = {hex_word[11:0], v[3:0]};
        if (digit_count < 2'd3) begin
            digit_count = digit_count + 2'd1;
            return;
        end
        digit_count = 2'd0;
        if (want_low) begin
            // Second half of a surrogate pair: join the two into a code point above 0xFFFF.
            want_low = 1'b0;
            if (hex_word < 16'hDC00 || hex_word > 16'hDFFF) begin
                push_err(ERR_LOW_RANGE);
                return;
            end
            joined = ({16'h0000, pending_high} << 10) + {16'h0000, hex_word} - 32'h035FDC00;
            parse_phase = PH_BODY;
            push_utf8(joined[20:0]);
            return;
        end
        if (hex_word >= 16'hD800 && hex_word <= 16'hDBFF) begin
            pending_high = hex_word;
            parse_phase  = PH_WANT_BSL;
            return;
        end
        if (hex_word >= 16'hDC00 && hex_word <= 16'hDFFF) begin
            push_err(ERR_LONE_LOW);
            return;
        end
        parse_phase = PH_BODY;
        push_utf8({5'b00000, hex_word});
    endfunction

    // Works out the results of one accepted input item into step_res.
    function automatic void decode_item(logic [7:0] b, logic st, logic eo);
        step_res.delete();
        if (st) begin
            clear_parse_state();
            if (eo) begin
                push_err(ERR_BAD_START);
            end else if (b == "\"") begin
                open_quote  = QK_DOUBLE;
                parse_phase = PH_BODY;
            end else if (b == "'") begin
                open_quote  = QK_SINGLE;
                parse_phase = PH_BODY;
            end else if (is_bare(b)) begin
                parse_phase = PH_BARE;
                push_data(b);
            end else begin
                push_err(ERR_BAD_START);
            end
        end else if (eo) begin
            case (parse_phase)
                PH_BARE: begin
                    parse_phase = PH_IDLE;
                    push_res(KIND_DONE, 8'h00, ERR_NONE, 1'b0);
                end
                PH_BODY, PH_SPACE:                         push_err(ERR_UNTERMINATED);
                PH_ESC:                                    push_err(ERR_ILLEGAL_ESC);
                PH_HEX:                                    push_err(ERR_BAD_HEX);
                PH_WANT_BSL, PH_WANT_U:                    push_err(ERR_LOW_MISSING);
                PH_MARK, PH_LINE, PH_BLOCK, PH_BLOCK_STAR: push_err(ERR_OPEN_COMMENT);
                default: ;
            endcase
        end else begin
            case (parse_phase)
                PH_BARE: begin
                    if (is_bare(b)) begin
                        push_data(b);
                    end else begin
                        parse_phase = PH_IDLE;
                        push_res(KIND_DONE, 8'h00, ERR_NONE, 1'b1);
                    end
                end
                PH_BODY: body_char(b);
                PH_ESC:  escape_char(b);
                PH_HEX:  hex_char(b);
                PH_WANT_BSL: begin
                    if (b == "\\") parse_phase = PH_WANT_U;
                    else push_err(ERR_LOW_MISSING);
                end
                PH_WANT_U: begin
                    if (b == "u") begin
                        parse_phase = PH_HEX;
                        digit_count = 2'd0;
                        hex_word    = 16'h0000;
                        want_low    = 1'b1;
                    end else begin
                        push_err(ERR_LOW_MISSING);
                    end
                end
                PH_SPACE: begin
                    if (b == " " || (b >= 8'h09 && b <= 8'h0D)) ;
                    else if (b == "/" || b == "#" || b == ";") parse_phase = PH_MARK;
                    else body_char(b);
                end
                PH_MARK: parse_phase = (b == "*") ? PH_BLOCK : PH_LINE;
                PH_LINE: begin
                    if (b == 8'h0A || b == 8'h0D || b == 8'h00) parse_phase = PH_SPACE;
                end
                PH_BLOCK: begin
                    if (b == 8'h00) push_err(ERR_NUL_IN_BLOCK);
                    else if (b == "*") parse_phase = PH_BLOCK_STAR;
                end
                PH_BLOCK_STAR: begin
                    if (b == 8'h00) push_err(ERR_NUL_IN_BLOCK);
                    else if (b == "/") parse_phase = PH_SPACE;
                    else if (b != "*") parse_phase = PH_BLOCK;
                end
                default: parse_phase = PH_IDLE;
            endcase
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: mismatch in %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_result(decoded_t d);
        decoded_q = {decoded_q, d};
    endfunction

    task automatic check_result();
        decoded_t w;
        if (decoded_q.size() == 0) begin
            flag_mismatch("result with nothing outstanding", m_tdata, 0);
            return;
        end
        w = decoded_q.pop_front();
        if (m_tuser != w.kind)         flag_mismatch("out_kind", m_tuser, w.kind);
        if (m_tdata[7:0] != w.data)    flag_mismatch("out_byte", m_tdata[7:0], w.data);
        if (m_tdata[11:8] != w.err)    flag_mismatch("error_code", m_tdata[11:8], w.err);
        if (m_tdata[12] != w.nc)       flag_mismatch("byte_not_consumed", m_tdata[12], w.nc);
        if (m_tlast != w.last)         flag_mismatch("last", m_tlast, w.last);
    endtask

    // Both handshakes are observed here at the rising edge; the model advances on acceptance.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) begin
                decode_item(s_tdata, s_tuser[0], s_tuser[1]);
                if (cur_row.typed) begin
                    if (cur_row.has_res)
                        queue_result(decoded_t'({cur_row.kind, cur_row.data, cur_row.err,
                                                 cur_row.nc, 1'b1}));
                end else begin
                    foreach (step_res[i]) queue_result(step_res[i]);
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("FAIL quoted_string_unescape_utf8_core");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Result sink: random stalls, calm stretches, and one long hold-off when asked.
    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                stall = rx_calm ? 0 : pick_gap();
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input stim_row_t row);
        int unsigned gap;
        bit          counted;
        counted = row.start || parse_phase != PH_IDLE;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.in_byte;
        s_tuser  <= {row.eot, row.start};
        cur_row  <= row;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (counted) items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void put_byte(logic [7:0] b, logic st = 1'b0, logic eo = 1'b0);
        stim_row_t r;
        r = '0;
        r.in_byte = b;
        r.start   = st;
        r.eot     = eo;
        tok_q = {tok_q, r};
    endfunction

    function automatic void put_eot();
        put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endfunction

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] hex_text(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    function automatic void put_u(logic [15:0] v);
        put_byte("\\");
        put_byte("u");
        for (int i = 3; i >= 0; i--) put_byte(hex_text(v[i*4 +: 4]));
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == "\"" || b == "'" || b == "\\");
        return b;
    endfunction

    function automatic logic [7:0] pick_space();
        logic [7:0] b;
        b = 8'($urandom_range(8'h09, 8'h0E));
        return (b == 8'h0E) ? " " : b;
    endfunction

    function automatic void put_unicode();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: put_u(16'($urandom_range(0, 16'h7F)));
            1: put_u(16'($urandom_range(16'h80, 16'h7FF)));
            2: begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
                put_u(v);
            end
            5: begin
                // Boundaries of each UTF-8 length and of the surrogate ranges.
                case ($urandom_range(0, 6))
                    0: put_u(16'h0000);
                    1: put_u(16'h007F);
                    2: put_u(16'h0080);
                    3: put_u(16'h07FF);
                    4: put_u(16'h0800);
                    5: put_u(16'hFFFF);
                    default: begin
                        put_u($urandom_range(0, 1) ? 16'hD800 : 16'hDBFF);
                        put_u($urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF);
                    end
                endcase
            end
            default: begin
                put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
        endcase
    endfunction

    // Backslash and line end, then blanks and comments, left on the next body byte.
    function automatic void put_continuation();
        put_byte("\\");
        put_byte($urandom_range(0, 1) ? 8'h0A : 8'h0D);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
                0: put_byte(pick_space());
                1: begin
                    put_byte(pick_from("/#;"));
                    put_byte(pick_from("xy/#; \t"));
                    repeat ($urandom_range(0, 4)) put_byte(pick_from("ab*/ \t#;"));
                    case ($urandom_range(0, 2))
                        0: put_byte(8'h0A);
                        1: put_byte(8'h0D);
                        default: put_byte(8'h00);
                    endcase
                end
                default: begin
                    put_byte(pick_from("/#;"));
                    put_byte("*");
                    repeat ($urandom_range(0, 5)) put_byte(pick_from("ab**\n #;"));
                    put_byte("*");
                    put_byte("/");
                end
            endcase
        end
    endfunction

    // Broken sequences: each error path and each way the text can end too soon.
    function automatic void put_broken(logic [7:0] q);
        case ($urandom_range(0, 12))
            0: begin
                put_byte("\\");
                put_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                put_byte("\\");
                put_byte((q == "\"") ? "'" : "\"");
            end
            2: begin
                put_byte("\\");
                put_byte("u");
                repeat ($urandom_range(0, 3)) put_byte(hex_text(4'($urandom_range(0, 15))));
                put_byte(pick_from("gGxz \"'"));
            end
            3: begin
                put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                put_byte(8'($urandom_range(0, 255)));
            end
            4: begin
                put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                put_byte("\\");
                put_byte(8'($urandom_range(0, 255)));
            end
            5: begin
                put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                put_u(16'($urandom_range(0, 16'hFFFF)));
            end
            6: put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            7: begin
                put_byte("\\");
                put_byte(8'h0A);
                put_byte(pick_from("/#;"));
                put_byte("*");
                if ($urandom_range(0, 1)) put_byte("*");
                put_byte(8'h00);
            end
            8: begin
                // Text ends right after a comment marker, or inside any kind of comment.
                put_byte("\\");
                put_byte(8'h0D);
                put_byte(pick_from("/#;"));
                case ($urandom_range(0, 3))
                    1: put_byte("*");
                    2: begin
                        put_byte("*");
                        put_byte("*");
                    end
                    3: put_byte("x");
                    default: ;
                endcase
                put_eot();
            end
            9: begin
                put_byte("\\");
                put_eot();
            end
            10: begin
                put_byte("\\");
                put_byte("u");
                repeat ($urandom_range(0, 3)) put_byte(hex_text(4'($urandom_range(0, 15))));
                put_eot();
            end
            11: begin
                put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                if ($urandom_range(0, 1)) put_byte("\\");
                put_eot();
            end
            default: begin
                put_byte("\\");
                put_byte(8'h0A);
                if ($urandom_range(0, 1)) put_byte(pick_space());
                put_eot();
            end
        endcase
    endfunction

    function automatic void gen_quoted();
        logic [7:0]  q;
        int unsigned r;
        q = $urandom_range(0, 1) ? "\"" : "'";
        put_byte(q, 1'b1);
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 30) put_byte(pick_text());
            else if (r < 50) begin
                put_byte("\\");
                put_byte($urandom_range(0, 8) == 8 ? q : pick_from("\\/bfnrtv"));
            end
            else if (r < 75) put_unicode();
            else if (r < 92) put_continuation();
            else put_broken(q);
        end
        r = $urandom_range(0, 9);
        if (r < 8) put_byte(q);
        else if (r == 8) put_eot();
    endfunction

    function automatic void gen_bare();
        logic [7:0]  b;
        int unsigned r;
        string       bare_set;
        bare_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-+_.";
        put_byte(pick_from(bare_set), 1'b1);
        repeat ($urandom_range(0, 6)) put_byte(pick_from(bare_set));
        r = $urandom_range(0, 99);
        if (r < 50) begin
            do b = 8'($urandom_range(0, 255)); while (is_bare(b));
            put_byte(b);
        end else if (r < 80) begin
            put_eot();
        end
    endfunction

    initial begin : stimulus
        int unsigned token_no;
        int unsigned r;
        clear_parse_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);
        drain_results();

        items_sent = 0;
        token_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            tx_burst = (token_no % 40) >= 30;
            rx_calm  = (token_no % 40) >= 30;
            // Long hold-off on the result side while items keep coming.
            if (token_no == 6 || token_no == 60) hold_req = 1'b1;
            if (token_no == 20 || token_no == 75) drain_results();
            tok_q.delete();
            r = $urandom_range(0, 99);
            if (r < 60) gen_quoted();
            else if (r < 85) gen_bare();
            else begin
                repeat ($urandom_range(1, 3))
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0);
            end
            while (tok_q.size() != 0) send_item(tok_q.pop_front());
            token_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("PASS quoted_string_unescape_utf8_core");
        end else begin
            $display("FAIL quoted_string_unescape_utf8_core");
        end
        $finish;
    end

endmodule
